FILE: rtl/ise_pkg.sv
// Package for the integer stack engine: types, codes and defaults.
`default_nettype none
package ise_pkg;

  localparam int DEF_STACK_DEPTH = 256;
  localparam int DATA_W          = 32;
  localparam int DEPTH_OUT_W     = 9;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_SWAP = 2'd2,
    CMD_ADD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_FULL       = 3'd1,
    STS_POP_EMPTY  = 3'd2,
    STS_SWAP_SHORT = 3'd3,
    STS_ADD_SHORT  = 3'd4
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] top_value;
    logic                     top_valid;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ise_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ise_ctrl.sv
// Controller state machine of the integer stack engine.
`default_nettype none
module ise_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ise_pkg::dp_sts_t sts,
  output ise_pkg::ctl_cmd_t     cmd
);
  import ise_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take a beat, then finish it once the result slot is free.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: if (in_valid) state_nxt = CS_EXEC;
      CS_EXEC: if (sts.out_free) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      CS_EXEC: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ise_dp.sv
// Datapath of the integer stack engine: cached top, entry RAM, count, result register.
`default_nettype none
module ise_dp #(
  parameter int STACK_DEPTH = ise_pkg::DEF_STACK_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ise_pkg::in_item_t in_data,
  input  wire ise_pkg::ctl_cmd_t cmd,
  output ise_pkg::dp_sts_t       sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ise_pkg::out_item_t     out_data
);
  import ise_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [CW-1:0] TWO      = CW'(2);

  cmd_t              cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [DATA_W-1:0] ram_q;
  status_t           status;

  // Entries below the top live in RAM at their own index; the top is cached.
  ise_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(top_r),
    .re   (ram_re),
    .raddr(AW'(count_r - TWO)),
    .rdata(ram_q)
  );

  // Fetch the entry under the top while the beat is taken.
  assign ram_re = cmd.capture && (count_r >= TWO);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= cmd_t'(in_data.command);
      val_r <= in_data.push_value;
    end
  end

  always_comb begin
    status    = STS_OK;
    count_nxt = count_r;
    top_nxt   = top_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(count_r - ONE);
    unique case (cmd_r)
      CMD_PUSH: begin
        if (count_r == FULL_CNT) begin
          status = STS_FULL;
        end else begin
          ram_we    = (count_r != '0);
          top_nxt   = val_r;
          count_nxt = count_r + ONE;
        end
      end
      CMD_POP: begin
        if (count_r == '0) begin
          status = STS_POP_EMPTY;
        end else begin
          top_nxt   = ram_q;
          count_nxt = count_r - ONE;
        end
      end
      CMD_SWAP: begin
        if (count_r < TWO) begin
          status = STS_SWAP_SHORT;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(count_r - TWO);
          top_nxt   = ram_q;
        end
      end
      CMD_ADD: begin
        if (count_r < TWO) begin
          status = STS_ADD_SHORT;
        end else begin
          top_nxt   = ram_q + top_r;
          count_nxt = count_r - ONE;
        end
      end
      default: status = STS_OK;
    endcase
    ram_we = ram_we && cmd.commit;

    out_nxt.status      = status;
    out_nxt.top_valid   = (count_nxt != '0);
    out_nxt.top_value   = (count_nxt != '0) ? top_nxt : '0;
    out_nxt.stack_depth = DEPTH_OUT_W'(count_nxt);
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_r <= top_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/integer_stack_engine.sv
// A result beat is registered when its input beat is finished, after the accept step.
// The engine takes no new beat until the last one is finished: the entry under the top
//   is read at accept, and the RAM is written at finish for a push or a swap.
// A stalled result holds the engine in its finish step until taken.
// Reset clears the entry count and handshake state; the entry RAM is not
//   cleared, since only entries below the count are ever read.
`default_nettype none
module integer_stack_engine #(
  parameter int STACK_DEPTH = ise_pkg::DEF_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ise_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ise_pkg::out_item_t      out_data
);
  import ise_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // Sequencer: take a beat in idle, finish it in exec when the output slot frees.
  ise_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (dp_sts),
    .cmd     (ctl_cmd)
  );

  // Datapath: cached top, entries below in RAM, count and the result register.
  ise_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (ctl_cmd),
    .sts      (dp_sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
